// ===== rtl/sstr_pkg.sv =====
// sstr_pkg: shared types, character codes and glyph table for the
// seven-segment text raster. No dependencies.
package sstr_pkg;

  localparam int MAX_DIGITS_DEF = 8;
  localparam int ROW_COUNT = 5;
  localparam int SCALE_W = 4;
  localparam int CHAR_W = 7;
  localparam int COL_W = 5;
  localparam int ROW_W = 3;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd2;
  localparam logic REG_SCALE = 1'b0;

  localparam logic [CHAR_W-1:0] CH_SP = 7'd32;
  localparam logic [CHAR_W-1:0] CH_DASH = 7'd45;
  localparam logic [CHAR_W-1:0] CH_BAR = 7'd124;
  localparam logic [CHAR_W-1:0] CH_NL = 7'd10;

  // segment bit order: top, upper-left, middle, upper-right, bottom,
  // lower-left, lower-right; codes 10 to 15 are blank
  localparam logic [6:0] SEG_MASK [0:15] = '{
    7'b1111011, 7'b1001000, 7'b0111101, 7'b1011101,
    7'b1001110, 7'b1010111, 7'b1110111, 7'b1001001,
    7'b1111111, 7'b1011111, 7'b0000000, 7'b0000000,
    7'b0000000, 7'b0000000, 7'b0000000, 7'b0000000
  };

  typedef enum logic {
    ST_COLLECT,
    ST_RENDER
  } ctrl_state_t;

  typedef struct packed {
    logic       op;
    logic [3:0] digit;
    logic       last_digit;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_frame;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic start;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_close;
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] glyph_char(input logic [3:0] d,
                                                   input logic [2:0] seg);
    logic [6:0] mask;
    logic [CHAR_W-1:0] ch;
    mask = SEG_MASK[d];
    if (!mask[seg]) begin
      ch = CH_SP;
    end else if (seg == 3'd0 || seg == 3'd2 || seg == 3'd4) begin
      ch = CH_DASH;
    end else begin
      ch = CH_BAR;
    end
    return ch;
  endfunction

endpackage

// ===== rtl/sstr_ctrl.sv =====
// sstr_ctrl: frame state machine, handshake and output valid flag.
// Depends on sstr_pkg.
module sstr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sstr_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sstr_pkg::ctrl_cmd_t cmd,
  input  sstr_pkg::dp_status_t status
);

  sstr_pkg::ctrl_state_t state, state_next;
  logic out_valid_next;
  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      sstr_pkg::ST_COLLECT: begin
        if (cmd.start) state_next = sstr_pkg::ST_RENDER;
      end
      sstr_pkg::ST_RENDER: begin
        if (cmd.load) begin
          state_next = cmd.start ? sstr_pkg::ST_RENDER : sstr_pkg::ST_COLLECT;
        end else if (cmd.emit && status.at_close) begin
          state_next = sstr_pkg::ST_COLLECT;
        end
      end
      default: state_next = sstr_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd.load = accept && !in_data.op;
    cmd.start = accept && !in_data.op && in_data.last_digit;
    cmd.restart = 1'b0;
    cmd.emit = 1'b0;
    case (state)
      sstr_pkg::ST_COLLECT: begin
      end
      sstr_pkg::ST_RENDER: begin
        cmd.restart = accept && !in_data.op;
        cmd.emit = accept && in_data.op;
      end
      default: begin
      end
    endcase
    out_valid_next = cmd.emit || (out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sstr_pkg::ST_COLLECT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/sstr_datapath.sv =====
// sstr_datapath: scale register, digit store, raster counters and
// output character register. Depends on sstr_pkg.
module sstr_datapath #(
  parameter int MAX_DIGITS = sstr_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sstr_pkg::ctrl_cmd_t           cmd,
  output sstr_pkg::dp_status_t          status,
  input  logic [3:0]                    digit,
  input  logic                          cfg_we,
  input  logic [sstr_pkg::SCALE_W-1:0]  cfg_wdata,
  output logic [sstr_pkg::SCALE_W-1:0]  scale,
  output sstr_pkg::out_word_t           out_data
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [3:0] store [MAX_DIGITS];
  logic [CW-1:0] digit_count, digit_count_next;
  logic [CW-1:0] digit_pos, digit_pos_next;
  logic [sstr_pkg::ROW_W-1:0] row_phase, row_phase_next;
  logic [sstr_pkg::SCALE_W-1:0] line_repeat, line_repeat_next;
  logic [sstr_pkg::COL_W-1:0] column_pos, column_pos_next;

  logic [CW-1:0] base;
  logic          base_room;
  logic [sstr_pkg::SCALE_W-1:0] s;
  logic [sstr_pkg::COL_W-1:0] s_w, col_inc, width;
  logic [sstr_pkg::SCALE_W:0] lr_inc;
  logic [3:0] cur_digit;
  logic last;
  logic [2:0] li, ri;
  logic [sstr_pkg::CHAR_W-1:0] ch;
  logic eof;

  assign s = (scale == '0) ? sstr_pkg::SCALE_W'(1) : scale;
  assign s_w = sstr_pkg::COL_W'(s);
  assign col_inc = column_pos + 1'b1;
  assign lr_inc = {1'b0, line_repeat} + 1'b1;
  assign last = ({1'b0, digit_pos} + 1'b1) == {1'b0, digit_count};
  assign base = cmd.restart ? '0 : digit_count;
  assign base_room = base < CW'(MAX_DIGITS);
  assign status.at_close = row_phase >= sstr_pkg::ROW_W'(sstr_pkg::ROW_COUNT);

  always_comb begin
    digit_count_next = digit_count;
    digit_pos_next = digit_pos;
    row_phase_next = row_phase;
    line_repeat_next = line_repeat;
    column_pos_next = column_pos;
    ch = sstr_pkg::CH_NL;
    eof = 1'b0;
    width = '0;
    li = row_phase[1] ? 3'd5 : 3'd1;
    ri = row_phase[1] ? 3'd6 : 3'd3;
    if (cmd.load) begin
      digit_count_next = base_room ? base + 1'b1 : base;
      if (cmd.start) begin
        row_phase_next = '0;
        line_repeat_next = '0;
        digit_pos_next = '0;
        column_pos_next = '0;
      end
    end else if (cmd.emit) begin
      if (status.at_close) begin
        eof = 1'b1;
        digit_count_next = '0;
        row_phase_next = '0;
        line_repeat_next = '0;
        digit_pos_next = '0;
        column_pos_next = '0;
      end else if (digit_pos >= digit_count) begin
        digit_pos_next = '0;
        column_pos_next = '0;
        if (row_phase[0]) begin
          if (lr_inc >= {1'b0, s}) begin
            line_repeat_next = '0;
            row_phase_next = row_phase + 1'b1;
          end else begin
            line_repeat_next = lr_inc[sstr_pkg::SCALE_W-1:0];
          end
        end else begin
          row_phase_next = row_phase + 1'b1;
        end
      end else begin
        if (!row_phase[0]) begin
          width = s_w + (last ? 5'd2 : 5'd3);
          ch = (column_pos >= 5'd1 && column_pos <= s_w) ?
               sstr_pkg::glyph_char(cur_digit, row_phase) : sstr_pkg::CH_SP;
        end else begin
          width = s_w + (last ? 5'd2 : 5'd3);
          if (column_pos == '0) begin
            ch = sstr_pkg::glyph_char(cur_digit, li);
          end else if (column_pos == s_w + 5'd1) begin
            ch = sstr_pkg::glyph_char(cur_digit, ri);
          end else begin
            ch = sstr_pkg::CH_SP;
          end
        end
        if (col_inc >= width) begin
          column_pos_next = '0;
          digit_pos_next = digit_pos + 1'b1;
        end else begin
          column_pos_next = col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= sstr_pkg::SCALE_RESET;
      digit_count <= '0;
      digit_pos <= '0;
      row_phase <= '0;
      line_repeat <= '0;
      column_pos <= '0;
    end else begin
      if (cfg_we) scale <= cfg_wdata;
      digit_count <= digit_count_next;
      digit_pos <= digit_pos_next;
      row_phase <= row_phase_next;
      line_repeat <= line_repeat_next;
      column_pos <= column_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && base_room) store[base[IW-1:0]] <= digit;
    // store read ahead into cur_digit, at the next draw position
    if (cmd.load && base_room && (base == digit_pos_next)) begin
      cur_digit <= digit;
    end else begin
      cur_digit <= store[digit_pos_next[IW-1:0]];
    end
    if (cmd.emit) begin
      out_data.char_code <= ch;
      out_data.end_of_frame <= eof;
    end
  end

endmodule

// ===== rtl/seven_segment_text_raster_top.sv =====
// seven_segment_text_raster_top: top level, controller plus datapath and
// the configuration port. Depends on sstr_pkg, sstr_ctrl, sstr_datapath.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    in_data (op, digit, last_digit)
//   out       output     out_valid/out_ready  out_data (char_code, end_of_frame)
//   cfg       input      psel/penable/pwrite  paddr, pwdata, prdata (scale at 0)
//
// one word accepted per cycle while in_ready is high; a tick in render state
// gives its character in the next cycle in the output register, from the raster counters and the glyph table
// in_ready is low only while an output word waits and out_ready is low
// synchronous reset, scale back to 2, digit store is not cleared
module seven_segment_text_raster_top #(
  parameter int MAX_DIGITS = sstr_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sstr_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sstr_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  sstr_pkg::ctrl_cmd_t cmd;
  sstr_pkg::dp_status_t status;
  logic [sstr_pkg::SCALE_W-1:0] scale;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == sstr_pkg::REG_SCALE);
  assign prdata = (paddr[2] == sstr_pkg::REG_SCALE) ? {28'd0, scale} : 32'd0;

  sstr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  sstr_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .digit     (in_data.digit),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[sstr_pkg::SCALE_W-1:0]),
    .scale     (scale),
    .out_data  (out_data)
  );

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("tick emit did not raise out_valid");

  a_eof_newline: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.end_of_frame) |-> (out_data.char_code == sstr_pkg::CH_NL))
    else $error("end of frame on a non-newline character");

  a_cmd_accepted: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.load) |-> (in_valid && in_ready && !(cmd.emit && cmd.load)))
    else $error("command without an accepted input word");

endmodule

// ===== tb/tb_seven_segment_text_raster_top.sv =====
`timescale 1ns / 100ps
// tb_seven_segment_text_raster_top: self-checking bench for the seven-segment
// text raster; a raster tracker class predicts every character word.
// Depends on sstr_pkg and seven_segment_text_raster_top.

localparam logic OP_LOAD = 1'b0;
localparam logic OP_TICK = 1'b1;

class raster_scoreboard;
  logic [3:0]          scale;
  logic [3:0]          digit_store [sstr_pkg::MAX_DIGITS_DEF];
  int                  digit_count;
  int                  row_phase;
  int                  line_repeat;
  int                  digit_pos;
  int                  column_pos;
  bit                  frame_ready;
  sstr_pkg::out_word_t pending_chars [$];
  int                  errors;

  function new();
    scale = sstr_pkg::SCALE_RESET;
    foreach (digit_store[i]) digit_store[i] = '0;
    digit_count = 0;
    frame_ready = 0;
    errors = 0;
    clear_raster();
  endfunction

  function void clear_raster();
    row_phase = 0;
    line_repeat = 0;
    digit_pos = 0;
    column_pos = 0;
  endfunction

  function logic [6:0] lit_segments(input logic [3:0] d);
    logic [6:0] m;
    case (d)
      4'd0: m = 7'b1111011;
      4'd1: m = 7'b1001000;
      4'd2: m = 7'b0111101;
      4'd3: m = 7'b1011101;
      4'd4: m = 7'b1001110;
      4'd5: m = 7'b1010111;
      4'd6: m = 7'b1110111;
      4'd7: m = 7'b1001001;
      4'd8: m = 7'b1111111;
      4'd9: m = 7'b1011111;
      default: m = 7'b0000000;
    endcase
    return m;
  endfunction

  function logic [6:0] segment_char(input logic [3:0] d, input int seg);
    logic [6:0] m;
    m = lit_segments(d);
    if (!m[seg]) return sstr_pkg::CH_SP;
    if (seg == 0 || seg == 2 || seg == 4) return sstr_pkg::CH_DASH;
    return sstr_pkg::CH_BAR;
  endfunction

  // stores a loaded digit or advances the raster for one accepted word
  function void note_word(input sstr_pkg::in_word_t w);
    int                  s;
    int                  width;
    bit                  last;
    logic [3:0]          d;
    logic [6:0]          ch;
    bit                  eof;
    sstr_pkg::out_word_t e;
    s = (scale == 0) ? 1 : int'(scale);
    if (w.op == OP_LOAD) begin
      if (frame_ready) begin
        frame_ready = 0;
        digit_count = 0;
      end
      if (digit_count < sstr_pkg::MAX_DIGITS_DEF) begin
        digit_store[digit_count] = w.digit;
        digit_count++;
      end
      if (w.last_digit) begin
        frame_ready = 1;
        clear_raster();
      end
      return;
    end
    if (!frame_ready) return;
    eof = 0;
    if (row_phase >= sstr_pkg::ROW_COUNT) begin
      ch = sstr_pkg::CH_NL;
      eof = 1;
      frame_ready = 0;
      digit_count = 0;
      clear_raster();
    end else if (digit_pos >= digit_count) begin
      ch = sstr_pkg::CH_NL;
      digit_pos = 0;
      column_pos = 0;
      if (row_phase % 2 == 1) begin
        line_repeat++;
        if (line_repeat >= s) begin
          line_repeat = 0;
          row_phase++;
        end
      end else begin
        row_phase++;
      end
    end else begin
      d = digit_store[digit_pos];
      last = (digit_pos + 1 == digit_count);
      if (row_phase % 2 == 0) begin
        width = 1 + s + (last ? 1 : 2);
        ch = (column_pos >= 1 && column_pos <= s) ? segment_char(d, row_phase)
                                                  : sstr_pkg::CH_SP;
      end else begin
        width = s + 2 + (last ? 0 : 1);
        if (column_pos == 0) ch = segment_char(d, (row_phase == 1) ? 1 : 5);
        else if (column_pos == s + 1) ch = segment_char(d, (row_phase == 1) ? 3 : 6);
        else ch = sstr_pkg::CH_SP;
      end
      column_pos++;
      if (column_pos >= width) begin
        column_pos = 0;
        digit_pos++;
      end
    end
    e.char_code = ch;
    e.end_of_frame = eof;
    pending_chars.push_back(e);
  endfunction

  function void check_word(input sstr_pkg::out_word_t got);
    sstr_pkg::out_word_t e;
    if (pending_chars.size() == 0) begin
      $display("%0t: unexpected word, actual char %0d eof %0b", $time,
               got.char_code, got.end_of_frame);
      errors++;
      return;
    end
    e = pending_chars.pop_front();
    if (got.char_code !== e.char_code) begin
      $display("%0t: char_code mismatch, expected %0d actual %0d", $time,
               e.char_code, got.char_code);
      errors++;
    end
    if (got.end_of_frame !== e.end_of_frame) begin
      $display("%0t: end_of_frame mismatch, expected %0b actual %0b", $time,
               e.end_of_frame, got.end_of_frame);
      errors++;
    end
  endfunction
endclass

module tb_seven_segment_text_raster_top;

  localparam logic [2:0] ADDR_SCALE = 3'd4 * sstr_pkg::REG_SCALE;
  localparam logic [2:0] ADDR_SPARE = 3'd4;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 30;
  localparam int FRAME_CAP = 160;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  sstr_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  sstr_pkg::out_word_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  raster_scoreboard sb = new();
  bit idle_on;
  int words_sent;
  int ready_hold;
  int stall;

  seven_segment_text_raster_top u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      ready_hold = $urandom_range(0, 4);
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(out_data);
  end

  initial begin
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) stall = 0;
      else stall++;
    end
    $display("** seven_segment_text_raster_top: FAILED **");
    $finish;
  end

  function automatic sstr_pkg::in_word_t load_word(input logic [3:0] d, input logic last);
    sstr_pkg::in_word_t w;
    w.op = OP_LOAD;
    w.digit = d;
    w.last_digit = last;
    return w;
  endfunction

  function automatic sstr_pkg::in_word_t tick_word();
    sstr_pkg::in_word_t w;
    w.op = OP_TICK;
    w.digit = 4'($urandom_range(0, 15));
    w.last_digit = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic logic [3:0] pick_digit();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  // frame words for each stored digit at the current scale
  function automatic int digit_cost();
    int s;
    s = (sb.scale == 0) ? 1 : int'(sb.scale);
    return (3 + 2 * s) * (s + 3);
  endfunction

  task automatic send_word(input sstr_pkg::in_word_t w);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    in_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    in_valid = 1'b0;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_SCALE) sb.scale = data[3:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_check_scale();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_SCALE;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {28'd0, sb.scale}) begin
      $display("%0t: scale readback mismatch, expected %0d actual %0d", $time,
               sb.scale, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_scale(input logic [3:0] value);
    logic [31:0] data;
    wait_drain();
    apb_write(ADDR_SPARE, $urandom);
    data = $urandom;
    data[3:0] = value;
    apb_write(ADDR_SCALE, data);
    apb_check_scale();
  endtask

  task automatic tick_out_frame();
    while (sb.frame_ready) send_word(tick_word());
  endtask

  // loads one number, then ticks through its frame or part of it
  task automatic play_number(input int n, input bit cut);
    int limit;
    int k;
    int pre;
    int stored;
    pre = 0;
    if (!cut && $urandom_range(0, 9) == 0) pre = $urandom_range(1, 3);
    stored = (pre + n > sstr_pkg::MAX_DIGITS_DEF) ? sstr_pkg::MAX_DIGITS_DEF : pre + n;
    if (stored * digit_cost() > FRAME_CAP) pre = 0;
    if (pre > 0) begin
      repeat (pre) send_word(load_word(pick_digit(), 1'b0));
      send_word(tick_word());
    end
    for (int i = 0; i < n; i++) send_word(load_word(pick_digit(), i == n - 1));
    limit = cut ? $urandom_range(1, 60) : 32'h7fffffff;
    k = 0;
    while (sb.frame_ready && k < limit) begin
      if ($urandom_range(0, 199) == 0) wait_drain();
      send_word(tick_word());
      k++;
    end
    if (!cut && $urandom_range(0, 3) == 0) send_word(tick_word());
  endtask

  task automatic run_phase(input logic [3:0] value, input int budget);
    int stop_at;
    int r;
    int n;
    int stored;
    set_scale(value);
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 9);
      if (r < 6) n = $urandom_range(1, 3);
      else if (r < 9) n = $urandom_range(4, 8);
      else n = $urandom_range(9, 10);
      stored = (n > sstr_pkg::MAX_DIGITS_DEF) ? sstr_pkg::MAX_DIGITS_DEF : n;
      if (stored * digit_cost() > FRAME_CAP) begin
        n = FRAME_CAP / digit_cost();
        if (n < 1) n = 1;
      end
      play_number(n, $urandom_range(0, 4) == 0);
    end
    tick_out_frame();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b0;
    words_sent = 0;
    ready_hold = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    apb_check_scale();
    set_scale(4'd1);
    send_word(tick_word());
    send_word(load_word(4'd8, 1'b1));
    repeat (3) send_word(tick_word());
    // restart while the frame is still rendering
    send_word(load_word(4'd15, 1'b1));
    tick_out_frame();
    send_word(tick_word());

    idle_on = 1'b1;
    run_phase(4'd0, PHASE_WORDS);
    set_scale(4'd15);
    play_number(1, 1'b0);
    run_phase(4'd1, PHASE_WORDS);
    run_phase(4'($urandom_range(2, 6)), PHASE_WORDS);
    run_phase(4'($urandom_range(2, 6)), PHASE_WORDS);
    idle_on = 1'b0;
    run_phase(4'($urandom_range(1, 6)), PHASE_WORDS);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** seven_segment_text_raster_top: PASSED **");
    end else begin
      $display("** seven_segment_text_raster_top: FAILED **");
    end
    $finish;
  end
endmodule
